### sv/lge_pkg.sv
`timescale 1ns / 1ps

package lge_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam int CELL_W = 6;
  localparam int SNAP_W = 5;
  localparam int TOTAL_W = 13;

  localparam logic [6:0] GRID_SIDE_RST = 7'd64;
  localparam int MIN_SIDE = 3;

  localparam logic [3:0] COUNT_MAX  = 4'd8;
  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 13'd8191;

  localparam logic [1:0] RING_FIRST = 2'd0;
  localparam logic [1:0] RING_MID   = 2'd1;
  localparam logic [1:0] RING_LAST  = 2'd2;

  localparam logic [2:0] K_INC    = 3'd0;
  localparam logic [2:0] K_DEC    = 3'd1;
  localparam logic [2:0] K_BORN   = 3'd2;
  localparam logic [2:0] K_DIE    = 3'd3;
  localparam logic [2:0] K_CLRCHG = 3'd4;

  typedef struct packed {
    logic [1:0] row_sel;
    logic [1:0] col_sel;
  } ring_pos_t;

  function automatic logic [CELL_W-1:0] cell_modify(input logic [CELL_W-1:0] v,
                                                    input logic [2:0] kind);
    logic [CELL_W-1:0] r;
    logic [3:0] cnt;
    r = v;
    cnt = v[4:1];
    unique case (kind)
      K_INC: begin
        if (cnt < COUNT_MAX) r[4:1] = cnt + 4'd1;
      end
      K_DEC: begin
        if (cnt != 4'd0) r[4:1] = cnt - 4'd1;
      end
      K_BORN: begin
        r[0] = 1'b1;
        r[5] = 1'b1;
      end
      K_DIE: begin
        r[0] = 1'b0;
        r[5] = 1'b1;
      end
      K_CLRCHG: begin
        r[5] = 1'b0;
      end
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

### sv/life_generation_engine_core.sv
`timescale 1ns / 1ps

// Toroidal B3/S23 Life engine. Cells (alive, cached neighbour count, changed flag) live in
// one single-port-write RAM of MAX_SIDE*MAX_SIDE entries, with a second RAM holding the
// generation snapshot. After reset the block sweeps both RAMs over all MAX_SIDE*MAX_SIDE
// entries (4096 at the default) before it takes its first transaction. A read, and a write
// to a cell whose state does not change, wait on one RAM read; a write that flips the cell
// also updates its eight neighbours by read-modify-writes, all paced by the registered RAM
// read. A generation step runs a copy pass over all MAX_SIDE*MAX_SIDE entries, a decision
// for each active cell, and nine read-modify-writes of the neighbourhood of each flipped
// cell. The result register frees the input as soon as a result is posted.
module life_generation_engine_core import lge_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,  // grid_side
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // op[1:0], row[7:2], col[13:8], alive_in[14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata     // alive_out[0], neighbour_count[4:1], changed[5],
                                    // change_total[18:6]
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW = $clog2(DEPTH);

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_WR_RD     = 4'd2;
  localparam logic [3:0] ST_WR_CMP    = 4'd3;
  localparam logic [3:0] ST_RD_RD     = 4'd4;
  localparam logic [3:0] ST_RD_DATA   = 4'd5;
  localparam logic [3:0] ST_COPY      = 4'd6;
  localparam logic [3:0] ST_COPY_LAST = 4'd7;
  localparam logic [3:0] ST_SNAP_RD   = 4'd8;
  localparam logic [3:0] ST_EVAL      = 4'd9;
  localparam logic [3:0] ST_RING      = 4'd10;
  localparam logic [3:0] ST_RING_LAST = 4'd11;
  localparam logic [3:0] ST_DONE      = 4'd12;

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       cnt_r, cnt_nxt;
  logic [6:0]          grid_side_r;
  logic [1:0]          op_r, op_nxt;
  logic                alive_in_r, alive_in_nxt;
  logic [CW-1:0]       scan_row_r, scan_row_nxt;
  logic [CW-1:0]       scan_col_r, scan_col_nxt;
  ring_pos_t           ring_pos_r, ring_pos_nxt;
  logic                ring_up_r, ring_up_nxt;
  logic                ring_skip_r, ring_skip_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic [2:0]          pend_kind_r, pend_kind_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic                res_alive_r, res_alive_nxt;
  logic [3:0]          res_count_r, res_count_nxt;
  logic                res_changed_r, res_changed_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [23:0]         out_data_r, out_data_nxt;

  logic [SW-1:0]       side;
  logic [1:0]          in_op;
  logic [5:0]          in_row;
  logic [5:0]          in_col;
  logic                in_alive;
  logic                in_range;
  logic                col_last;
  logic                row_last;
  logic [CW-1:0]       next_row;
  logic [CW-1:0]       next_col;
  logic [AW-1:0]       scan_addr;
  logic [AW-1:0]       ring_addr;
  ring_pos_t           ring_pos_inc;
  logic                ring_at_end;
  logic                ring_at_mid;
  logic [3:0]          snap_cnt;
  logic                snap_alive;
  logic                flip;

  logic                cell_we;
  logic [AW-1:0]       cell_waddr;
  logic [CELL_W-1:0]   cell_wdata;
  logic [AW-1:0]       cell_raddr;
  logic [CELL_W-1:0]   cell_rdata;
  logic                snap_we;
  logic [AW-1:0]       snap_waddr;
  logic [SNAP_W-1:0]   snap_wdata;
  logic [AW-1:0]       snap_raddr;
  logic [SNAP_W-1:0]   snap_rdata;

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return AW'(r) * AW'(MAX_SIDE) + AW'(c);
  endfunction

  lge_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  lge_ram #(.WIDTH(SNAP_W), .DEPTH(DEPTH)) u_snap_ram (
    .clk   (clk),
    .we    (snap_we),
    .waddr (snap_waddr),
    .wdata (snap_wdata),
    .raddr (snap_raddr),
    .rdata (snap_rdata)
  );

  lge_ring_agen #(.MAX_SIDE(MAX_SIDE)) u_ring_agen (
    .center_row (scan_row_r),
    .center_col (scan_col_r),
    .side       (side),
    .pos        (ring_pos_r),
    .addr       (ring_addr)
  );

  always_comb begin
    if (grid_side_r < 7'(MIN_SIDE)) side = SW'(MIN_SIDE);
    else if (32'(grid_side_r) > 32'(MAX_SIDE)) side = SW'(MAX_SIDE);
    else side = SW'(grid_side_r);
  end

  assign in_op    = in_tdata[1:0];
  assign in_row   = in_tdata[7:2];
  assign in_col   = in_tdata[13:8];
  assign in_alive = in_tdata[14];
  assign in_range = (32'(in_row) < 32'(side)) && (32'(in_col) < 32'(side));

  assign col_last = (32'(scan_col_r) + 32'd1) == 32'(side);
  assign row_last = (32'(scan_row_r) + 32'd1) == 32'(side);
  assign next_col = col_last ? '0 : scan_col_r + 1'b1;
  assign next_row = col_last ? scan_row_r + 1'b1 : scan_row_r;
  assign scan_addr = addr_of(scan_row_r, scan_col_r);

  always_comb begin
    ring_pos_inc = ring_pos_r;
    if (ring_pos_r.col_sel == RING_LAST) begin
      ring_pos_inc.col_sel = RING_FIRST;
      ring_pos_inc.row_sel = ring_pos_r.row_sel + 2'd1;
    end else begin
      ring_pos_inc.col_sel = ring_pos_r.col_sel + 2'd1;
    end
    if (ring_skip_r && ring_pos_inc.row_sel == RING_MID && ring_pos_inc.col_sel == RING_MID) begin
      ring_pos_inc.col_sel = RING_LAST;
    end
  end

  assign ring_at_end = (ring_pos_r.row_sel == RING_LAST) && (ring_pos_r.col_sel == RING_LAST);
  assign ring_at_mid = (ring_pos_r.row_sel == RING_MID) && (ring_pos_r.col_sel == RING_MID);

  assign snap_alive = snap_rdata[0];
  assign snap_cnt   = snap_rdata[4:1];
  assign flip = snap_alive ? !(snap_cnt == SURVIVE_LO || snap_cnt == BIRTH_CNT)
                           : (snap_cnt == BIRTH_CNT);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    op_nxt          = op_r;
    alive_in_nxt    = alive_in_r;
    scan_row_nxt    = scan_row_r;
    scan_col_nxt    = scan_col_r;
    ring_pos_nxt    = ring_pos_r;
    ring_up_nxt     = ring_up_r;
    ring_skip_nxt   = ring_skip_r;
    pend_vld_nxt    = 1'b0;
    pend_addr_nxt   = pend_addr_r;
    pend_kind_nxt   = pend_kind_r;
    total_nxt       = total_r;
    res_alive_nxt   = res_alive_r;
    res_count_nxt   = res_count_r;
    res_changed_nxt = res_changed_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;

    cell_we    = pend_vld_r;
    cell_waddr = pend_addr_r;
    cell_wdata = cell_modify(cell_rdata, pend_kind_r);
    cell_raddr = scan_addr;
    snap_we    = pend_vld_r && (pend_kind_r == K_CLRCHG);
    snap_waddr = pend_addr_r;
    snap_wdata = cell_rdata[SNAP_W-1:0];
    snap_raddr = scan_addr;

    unique case (state_r)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = cnt_r;
        cell_wdata = '0;
        snap_we    = 1'b1;
        snap_waddr = cnt_r;
        snap_wdata = '0;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt          = in_op;
          alive_in_nxt    = in_alive;
          scan_row_nxt    = CW'(in_row);
          scan_col_nxt    = CW'(in_col);
          total_nxt       = '0;
          res_alive_nxt   = 1'b0;
          res_count_nxt   = '0;
          res_changed_nxt = 1'b0;
          cnt_nxt         = '0;
          unique case (in_op)
            OP_WRITE: state_nxt = in_range ? ST_WR_RD : ST_DONE;
            OP_READ:  state_nxt = in_range ? ST_RD_RD : ST_DONE;
            OP_STEP:  state_nxt = ST_COPY;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_WR_RD: begin
        state_nxt = ST_WR_CMP;
      end
      ST_WR_CMP: begin
        if (cell_rdata[0] != alive_in_r) begin
          cell_we       = 1'b1;
          cell_waddr    = scan_addr;
          cell_wdata    = {cell_rdata[CELL_W-1:1], alive_in_r};
          ring_up_nxt   = alive_in_r;
          ring_skip_nxt = 1'b1;
          ring_pos_nxt  = '0;
          state_nxt     = ST_RING;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_RD: begin
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        res_alive_nxt   = cell_rdata[0];
        res_count_nxt   = cell_rdata[4:1];
        res_changed_nxt = cell_rdata[5];
        state_nxt       = ST_DONE;
      end
      ST_COPY: begin
        cell_raddr    = cnt_r;
        pend_vld_nxt  = 1'b1;
        pend_addr_nxt = cnt_r;
        pend_kind_nxt = K_CLRCHG;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == AW'(DEPTH - 1)) state_nxt = ST_COPY_LAST;
      end
      ST_COPY_LAST: begin
        scan_row_nxt = '0;
        scan_col_nxt = '0;
        state_nxt    = ST_SNAP_RD;
      end
      ST_SNAP_RD: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (flip) begin
          if (total_r != TOTAL_MAX) total_nxt = total_r + 1'b1;
          ring_up_nxt   = !snap_alive;
          ring_skip_nxt = 1'b0;
          ring_pos_nxt  = '0;
          state_nxt     = ST_RING;
        end else if (col_last && row_last) begin
          state_nxt = ST_DONE;
        end else begin
          snap_raddr   = addr_of(next_row, next_col);
          scan_row_nxt = next_row;
          scan_col_nxt = next_col;
        end
      end
      ST_RING: begin
        cell_raddr    = ring_addr;
        pend_vld_nxt  = 1'b1;
        pend_addr_nxt = ring_addr;
        if (ring_at_mid) pend_kind_nxt = ring_up_r ? K_BORN : K_DIE;
        else pend_kind_nxt = ring_up_r ? K_INC : K_DEC;
        ring_pos_nxt = ring_pos_inc;
        if (ring_at_end) state_nxt = ST_RING_LAST;
      end
      ST_RING_LAST: begin
        if (op_r != OP_STEP || (col_last && row_last)) begin
          state_nxt = ST_DONE;
        end else begin
          scan_row_nxt = next_row;
          scan_col_nxt = next_col;
          state_nxt    = ST_SNAP_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, total_r, res_changed_r, res_count_r, res_alive_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      grid_side_r <= GRID_SIDE_RST;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) grid_side_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    alive_in_r    <= alive_in_nxt;
    scan_row_r    <= scan_row_nxt;
    scan_col_r    <= scan_col_nxt;
    ring_pos_r    <= ring_pos_nxt;
    ring_up_r     <= ring_up_nxt;
    ring_skip_r   <= ring_skip_nxt;
    pend_addr_r   <= pend_addr_nxt;
    pend_kind_r   <= pend_kind_nxt;
    total_r       <= total_nxt;
    res_alive_r   <= res_alive_nxt;
    res_count_r   <= res_count_nxt;
    res_changed_r <= res_changed_nxt;
    out_data_r    <= out_data_nxt;
  end

  a_no_double_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR_CMP) |-> !pend_vld_r)
    else $error("center write collides with pending ring write");

  a_ring_skips_center: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RING && ring_skip_r) |-> !ring_at_mid)
    else $error("cell write ring visits its own center");

  a_snap_write_window: assert property (@(posedge clk) disable iff (!rst_n)
    snap_we |-> (state_r == ST_CLEAR || state_r == ST_COPY || state_r == ST_COPY_LAST))
    else $error("snapshot written outside clear or copy pass");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_tready) |=> (state_r == ST_DONE))
    else $error("result dropped while output stalled");

endmodule

### sv/lge_ram.sv
`timescale 1ns / 1ps

module lge_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### sv/lge_ring_agen.sv
`timescale 1ns / 1ps

module lge_ring_agen import lge_pkg::*; #(
  parameter int MAX_SIDE = 64
) (
  input  logic [$clog2(MAX_SIDE)-1:0]          center_row,
  input  logic [$clog2(MAX_SIDE)-1:0]          center_col,
  input  logic [$clog2(MAX_SIDE+1)-1:0]        side,
  input  ring_pos_t                            pos,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0] addr
);

  localparam int CW = $clog2(MAX_SIDE);
  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);

  logic [CW-1:0] side_m1;
  logic [CW-1:0] row_sel;
  logic [CW-1:0] col_sel;

  assign side_m1 = CW'(side - 1'b1);

  function automatic logic [CW-1:0] wrap(input logic [CW-1:0] c,
                                         input logic [1:0] sel,
                                         input logic [CW-1:0] last,
                                         input logic [$clog2(MAX_SIDE+1)-1:0] s);
    logic [CW-1:0] r;
    r = c;
    case (sel)
      RING_FIRST: r = (c == '0) ? last : c - 1'b1;
      RING_LAST: r = ((32'(c) + 32'd1) >= 32'(s)) ? '0 : c + 1'b1;
      default: r = c;
    endcase
    return r;
  endfunction

  assign row_sel = wrap(center_row, pos.row_sel, side_m1, side);
  assign col_sel = wrap(center_col, pos.col_sel, side_m1, side);
  assign addr = AW'(row_sel) * AW'(MAX_SIDE) + AW'(col_sel);

endmodule
